// ===== hdl/elfs_pkg.sv =====
package elfs_pkg;

    // Colour temperature limits in mired, the shortest and longest fade in milliseconds and the elapsed-time ceiling.
    localparam logic [8:0]  CT_MIN      = 9'd200;
    localparam logic [8:0]  CT_MAX      = 9'd455;
    localparam logic [19:0] FADE_MIN    = 20'd1;
    localparam logic [19:0] FADE_MAX    = 20'd900000;
    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

    // Register values after reset.
    localparam logic [7:0]  RST_START_BRIGHTNESS = 8'd1;
    localparam logic [7:0]  RST_END_BRIGHTNESS   = 8'd128;
    localparam logic [8:0]  RST_START_COLOR_TEMP = 9'd455;
    localparam logic [8:0]  RST_END_COLOR_TEMP   = 9'd200;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_STOP  = 2'd2
    } req_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [2:0] {
        STAT_STARTED  = 3'd0,
        STAT_STEP     = 3'd1,
        STAT_FINISHED = 3'd2,
        STAT_FROZEN   = 3'd3,
        STAT_REJECTED = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_START_BRIGHTNESS = 3'd0,
        CFG_END_BRIGHTNESS   = 3'd1,
        CFG_START_COLOR_TEMP = 3'd2,
        CFG_END_COLOR_TEMP   = 3'd3,
        CFG_FADE_LENGTH_MS   = 3'd4,
        CFG_FADE_ENABLE      = 3'd5
    } cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MUL_T2,
        ST_MUL_S,
        ST_BLEND_B,
        ST_BLEND_C,
        ST_EMIT
    } state_t;

    // Current register contents.
    typedef struct packed {
        logic [7:0]  start_brightness;
        logic [7:0]  end_brightness;
        logic [8:0]  start_color_temp;
        logic [8:0]  end_color_temp;
        logic [19:0] fade_length_ms;
        logic        fade_enable;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic tick;
        logic finish;
        logic stop;
        logic reject;
        logic div_step;
        logic mul_t2;
        logic mul_s;
        logic blend_b;
        logic blend_c;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req;
        logic       running;
        logic       enable;
        logic       reached;
        logic       div_last;
    } dp_stat_t;

endpackage

// ===== hdl/eased_light_fade_sequencer.sv =====
// Flow: start, stop, rejected and finishing tick requests go from the evaluate state to the emit state, which
// raises m_tvalid; an in-progress tick that has not reached the fade length first runs the one-bit-per-cycle
// divider, followed by two multiply steps and two blend steps.
// Requests are taken one at a time, since s_tready is high only in the idle state; a result
// still waiting in the output register holds off the next one.
// Reset: synchronous, active low; control, fade state and output valid clear; settings take their reset values.
module eased_light_fade_sequencer #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] ms_passed
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] brightness, [16:8] color_temp,
                                   // [17] fade_running, [18] lamp_on, [23:19] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    elfs_pkg::cfg_t     cfg;
    elfs_pkg::dp_cmd_t  cmd;
    elfs_pkg::dp_stat_t stat;
    logic [7:0]         out_brightness;
    logic [8:0]         out_color_temp;
    logic [2:0]         out_status;
    logic               out_fade_running;
    logic               out_lamp_on;

    elfs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    elfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    elfs_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .s_req            (s_tuser),
        .s_ms             (s_tdata),
        .out_brightness   (out_brightness),
        .out_color_temp   (out_color_temp),
        .out_status       (out_status),
        .out_fade_running (out_fade_running),
        .out_lamp_on      (out_lamp_on)
    );

    // Pack the result beat.
    assign m_tdata = {5'd0, out_lamp_on, out_fade_running, out_color_temp, out_brightness};
    assign m_tuser = out_status;

endmodule

// ===== hdl/elfs_cfg.sv =====
module elfs_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    output elfs_pkg::cfg_t       cfg
);

    elfs_pkg::cfg_t cfg_reg;
    elfs_pkg::cfg_t cfg_next;
    logic [8:0]     ct_clamped;
    logic [19:0]    fade_clamped;

    // Write values are clamped into their legal ranges.
    always_comb begin
        if (cfg_data[8:0] < elfs_pkg::CT_MIN) begin
            ct_clamped = elfs_pkg::CT_MIN;
        end else if (cfg_data[8:0] > elfs_pkg::CT_MAX) begin
            ct_clamped = elfs_pkg::CT_MAX;
        end else begin
            ct_clamped = cfg_data[8:0];
        end
        if (cfg_data < elfs_pkg::FADE_MIN) begin
            fade_clamped = elfs_pkg::FADE_MIN;
        end else if (cfg_data > elfs_pkg::FADE_MAX) begin
            fade_clamped = elfs_pkg::FADE_MAX;
        end else begin
            fade_clamped = cfg_data;
        end
    end

    // Register write decode; indexes past the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                elfs_pkg::CFG_START_BRIGHTNESS: cfg_next.start_brightness = cfg_data[7:0];
                elfs_pkg::CFG_END_BRIGHTNESS:   cfg_next.end_brightness   = cfg_data[7:0];
                elfs_pkg::CFG_START_COLOR_TEMP: cfg_next.start_color_temp = ct_clamped;
                elfs_pkg::CFG_END_COLOR_TEMP:   cfg_next.end_color_temp   = ct_clamped;
                elfs_pkg::CFG_FADE_LENGTH_MS:   cfg_next.fade_length_ms   = fade_clamped;
                elfs_pkg::CFG_FADE_ENABLE:      cfg_next.fade_enable      = cfg_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_brightness <= elfs_pkg::RST_START_BRIGHTNESS;
            cfg_reg.end_brightness   <= elfs_pkg::RST_END_BRIGHTNESS;
            cfg_reg.start_color_temp <= elfs_pkg::RST_START_COLOR_TEMP;
            cfg_reg.end_color_temp   <= elfs_pkg::RST_END_COLOR_TEMP;
            cfg_reg.fade_length_ms   <= elfs_pkg::FADE_MAX;
            cfg_reg.fade_enable      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/elfs_dp.sv =====
module elfs_dp #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  elfs_pkg::cfg_t       cfg,
    input  elfs_pkg::dp_cmd_t    cmd,
    output elfs_pkg::dp_stat_t   stat,
    input  logic [1:0]           s_req,
    input  logic [15:0]          s_ms,
    output logic [7:0]           out_brightness,
    output logic [8:0]           out_color_temp,
    output logic [2:0]           out_status,
    output logic                 out_fade_running,
    output logic                 out_lamp_on
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = $clog2(F);
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

    // Request capture
    logic [1:0]   req_reg;
    logic [15:0]  ms_reg;

    // Fade state
    logic         running_reg;
    logic [19:0]  elapsed_reg;
    logic [7:0]   last_b_reg;
    logic [8:0]   last_ct_reg;
    logic [2:0]   status_reg;

    // Settings latched at start
    logic [7:0]   lat_sb_reg;
    logic [7:0]   lat_eb_reg;
    logic [8:0]   lat_sc_reg;
    logic [8:0]   lat_ec_reg;
    logic [19:0]  lat_fade_reg;

    // Divider and multiplier stages
    logic [19:0]  rem_reg;
    logic [F-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic [F-1:0] t2_reg;
    logic [F:0]   s_reg;

    // Result register
    logic [7:0]   ob_reg;
    logic [8:0]   oct_reg;
    logic [2:0]   ost_reg;
    logic         orun_reg;
    logic         olamp_reg;

    logic [20:0]  e_sum;
    logic [19:0]  e_sat;
    logic [20:0]  rem_shift;
    logic         rem_ge;
    logic [2*F-1:0] t2_full;
    logic [F+1:0] tw;
    logic [2*F+1:0] s_full;
    logic [8:0]   bl_a;
    logic [8:0]   bl_b;
    logic signed [9:0]   bl_diff;
    logic signed [F+11:0] bl_prod;
    logic signed [F+11:0] bl_num;
    logic [9:0]   bl_val;
    logic [8:0]   ct_clamped;

    // Elapsed time update with saturation.
    always_comb begin
        e_sum = {1'b0, elapsed_reg} + 21'(ms_reg);
        e_sat = e_sum[20] ? elfs_pkg::ELAPSED_MAX : e_sum[19:0];
    end

    // One restoring divide step: the remainder stays below the fade length while dividing.
    always_comb begin
        rem_shift = {rem_reg, 1'b0};
        rem_ge    = rem_shift >= {1'b0, lat_fade_reg};
    end

    // Smoothstep products: t*t, then t2*(3 - 2t).
    always_comb begin
        t2_full = (2*F)'(quo_reg) * (2*F)'(quo_reg);
        tw      = THREE_ONE - {1'b0, quo_reg, 1'b0};
        s_full  = (2*F+2)'(t2_reg) * (2*F+2)'(tw);
    end

    // Shared blend unit: start + (end - start) * s, truncated and floored at zero.
    always_comb begin
        bl_a    = cmd.blend_c ? lat_sc_reg : {1'b0, lat_sb_reg};
        bl_b    = cmd.blend_c ? lat_ec_reg : {1'b0, lat_eb_reg};
        bl_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
        bl_prod = (F+12)'(bl_diff) * $signed((F+12)'(s_reg));
        bl_num  = $signed((F+12)'({bl_a, {F{1'b0}}})) + bl_prod;
        bl_val  = bl_num[F+11] ? 10'd0 : bl_num[F+9:F];
        if (bl_val < 10'(elfs_pkg::CT_MIN)) begin
            ct_clamped = elfs_pkg::CT_MIN;
        end else if (bl_val > 10'(elfs_pkg::CT_MAX)) begin
            ct_clamped = elfs_pkg::CT_MAX;
        end else begin
            ct_clamped = bl_val[8:0];
        end
    end

    // Control state of the fade.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            last_b_reg  <= '0;
            last_ct_reg <= '0;
        end else begin
            if (cmd.start) begin
                running_reg <= 1'b1;
                elapsed_reg <= '0;
                last_b_reg  <= cfg.start_brightness;
                last_ct_reg <= cfg.start_color_temp;
            end
            if (cmd.tick) begin
                elapsed_reg <= e_sat;
            end
            if (cmd.finish) begin
                running_reg <= 1'b0;
                last_b_reg  <= lat_eb_reg;
                last_ct_reg <= lat_ec_reg;
            end
            if (cmd.stop) begin
                running_reg <= 1'b0;
            end
            if (cmd.blend_b) begin
                last_b_reg <= bl_val[7:0];
            end
            if (cmd.blend_c) begin
                last_ct_reg <= ct_clamped;
            end
        end
    end

    // Payload registers: request, latched settings, arithmetic and result.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req;
            ms_reg  <= s_ms;
        end
        if (cmd.start) begin
            lat_sb_reg   <= cfg.start_brightness;
            lat_eb_reg   <= cfg.end_brightness;
            lat_sc_reg   <= cfg.start_color_temp;
            lat_ec_reg   <= cfg.end_color_temp;
            lat_fade_reg <= cfg.fade_length_ms;
            status_reg   <= elfs_pkg::STAT_STARTED;
        end
        if (cmd.tick) begin
            rem_reg <= e_sat;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.finish) begin
            status_reg <= elfs_pkg::STAT_FINISHED;
        end
        if (cmd.stop) begin
            status_reg <= elfs_pkg::STAT_FROZEN;
        end
        if (cmd.reject) begin
            status_reg <= elfs_pkg::STAT_REJECTED;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? 20'(rem_shift - {1'b0, lat_fade_reg}) : rem_shift[19:0];
            quo_reg <= {quo_reg[F-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul_t2) begin
            t2_reg <= t2_full[2*F-1:F];
        end
        if (cmd.mul_s) begin
            s_reg <= s_full[2*F:F];
        end
        if (cmd.blend_c) begin
            status_reg <= elfs_pkg::STAT_STEP;
        end
        if (cmd.emit) begin
            ob_reg    <= last_b_reg;
            oct_reg   <= last_ct_reg;
            ost_reg   <= status_reg;
            orun_reg  <= running_reg;
            olamp_reg <= last_b_reg != 8'd0;
        end
    end

    always_comb begin
        stat.req      = req_reg;
        stat.running  = running_reg;
        stat.enable   = cfg.fade_enable;
        stat.reached  = e_sat >= lat_fade_reg;
        stat.div_last = cnt_reg == CW'(F - 1);
    end

    assign out_brightness   = ob_reg;
    assign out_color_temp   = oct_reg;
    assign out_status       = ost_reg;
    assign out_fade_running = orun_reg;
    assign out_lamp_on      = olamp_reg;

endmodule

// ===== hdl/elfs_ctrl.sv =====
module elfs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  elfs_pkg::dp_stat_t   stat,
    output elfs_pkg::dp_cmd_t    cmd
);

    elfs_pkg::state_t state_reg;
    elfs_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             tick_ok;

    assign out_free = !out_valid_reg || m_tready;
    assign tick_ok  = stat.req == elfs_pkg::REQ_TICK && stat.running;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            elfs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = elfs_pkg::ST_EVAL;
                end
            end
            elfs_pkg::ST_EVAL: begin
                if (tick_ok && !stat.reached) begin
                    state_next = elfs_pkg::ST_DIV;
                end else begin
                    state_next = elfs_pkg::ST_EMIT;
                end
            end
            elfs_pkg::ST_DIV: begin
                if (stat.div_last) begin
                    state_next = elfs_pkg::ST_MUL_T2;
                end
            end
            elfs_pkg::ST_MUL_T2:  state_next = elfs_pkg::ST_MUL_S;
            elfs_pkg::ST_MUL_S:   state_next = elfs_pkg::ST_BLEND_B;
            elfs_pkg::ST_BLEND_B: state_next = elfs_pkg::ST_BLEND_C;
            elfs_pkg::ST_BLEND_C: state_next = elfs_pkg::ST_EMIT;
            elfs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = elfs_pkg::ST_IDLE;
                end
            end
            default: state_next = elfs_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            elfs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            elfs_pkg::ST_EVAL: begin
                case (stat.req)
                    elfs_pkg::REQ_START: begin
                        cmd.start  = stat.enable && !stat.running;
                        cmd.reject = !(stat.enable && !stat.running);
                    end
                    elfs_pkg::REQ_TICK: begin
                        cmd.tick   = stat.running;
                        cmd.finish = stat.running && stat.reached;
                        cmd.reject = !stat.running;
                    end
                    elfs_pkg::REQ_STOP: begin
                        cmd.stop   = stat.running;
                        cmd.reject = !stat.running;
                    end
                    default: cmd.reject = 1'b1;
                endcase
            end
            elfs_pkg::ST_DIV:     cmd.div_step = 1'b1;
            elfs_pkg::ST_MUL_T2:  cmd.mul_t2   = 1'b1;
            elfs_pkg::ST_MUL_S:   cmd.mul_s    = 1'b1;
            elfs_pkg::ST_BLEND_B: cmd.blend_b  = 1'b1;
            elfs_pkg::ST_BLEND_C: cmd.blend_c  = 1'b1;
            elfs_pkg::ST_EMIT:    cmd.emit     = out_free;
            default: cmd = '0;
        endcase
    end

    // Output valid: set when a result is loaded, cleared when the beat is taken.
    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= elfs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== hdl/elfs_chk.sv =====
module elfs_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // The lamp flag follows the brightness field.
    a_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18] == (m_tdata[7:0] != 8'd0)))
        else $error("lamp_on disagrees with brightness");

    // Started and stepping results report a running fade; finished and frozen ones do not.
    a_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (((m_tuser == elfs_pkg::STAT_STARTED || m_tuser == elfs_pkg::STAT_STEP)
              && m_tdata[17])
          || ((m_tuser == elfs_pkg::STAT_FINISHED || m_tuser == elfs_pkg::STAT_FROZEN)
              && !m_tdata[17])
          || (m_tuser == elfs_pkg::STAT_REJECTED)))
        else $error("fade_running inconsistent with status");

    // Any colour temperature shown while a fade is running lies in the legal range.
    a_ct: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[17]) |->
            (m_tdata[16:8] >= elfs_pkg::CT_MIN && m_tdata[16:8] <= elfs_pkg::CT_MAX))
        else $error("colour temperature out of range during fade");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind eased_light_fade_sequencer elfs_chk u_elfs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
